// ----- hdl/seglcd_pkg.sv -----
// Shared types, constants and segment decode functions for the segment LCD driver.
`default_nettype none

package seglcd_pkg;

    localparam int NUM_COM = 4;
    localparam int NUM_SEG_PINS = 6;
    localparam int NUM_PINS = NUM_COM + NUM_SEG_PINS;

    // Configuration register indexes.
    localparam logic REG_REFRESH_PERIOD = 1'b0;
    localparam logic REG_COUNT_PERIOD   = 1'b1;

    localparam logic [7:0]  REFRESH_PERIOD_RST = 8'd30;
    localparam logic [15:0] COUNT_PERIOD_RST   = 16'd10000;
    localparam logic [NUM_PINS-1:0] PIN_LEVELS_RST = '1;

    // Symbol codes beyond the decimal digits.
    localparam logic [3:0] SYM_DEG_C = 4'd10;
    localparam logic [3:0] SYM_BLANK = 4'd11;

    typedef struct packed {
        logic [7:0]  refresh_period;
        logic [15:0] count_period;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic tick;
    } stage_t;

    // Lit segments of a symbol, one bit per segment code (A=10..F=15, G=9).
    function automatic logic [15:0] seg_lit(input logic [3:0] sym);
        logic [15:0] lit;
        unique case (sym)
            4'd0:      lit = 16'hFC00;
            4'd1:      lit = 16'h1800;
            4'd2:      lit = 16'h6E00;
            4'd3:      lit = 16'h3E00;
            4'd4:      lit = 16'h9A00;
            4'd5:      lit = 16'hB600;
            4'd6:      lit = 16'hF600;
            4'd7:      lit = 16'h1C00;
            4'd8:      lit = 16'hFE00;
            4'd9:      lit = 16'hBE00;
            SYM_DEG_C: lit = 16'h2400;
            default:   lit = 16'h0000;
        endcase
        return lit;
    endfunction

    // Glass map: digit position in the high nibble, segment code in the low nibble.
    function automatic logic [7:0] com_seg_code(input logic [1:0] com, input logic [2:0] pin);
        logic [7:0] code;
        unique case ({com, pin})
            {2'd0, 3'd0}: code = 8'h49;
            {2'd0, 3'd1}: code = 8'h1A;
            {2'd0, 3'd2}: code = 8'h4D;
            {2'd0, 3'd3}: code = 8'h2A;
            {2'd0, 3'd4}: code = 8'h4A;
            {2'd0, 3'd5}: code = 8'h3A;
            {2'd1, 3'd0}: code = 8'h1F;
            {2'd1, 3'd1}: code = 8'h1B;
            {2'd1, 3'd2}: code = 8'h2F;
            {2'd1, 3'd3}: code = 8'h2B;
            {2'd1, 3'd4}: code = 8'h3F;
            {2'd1, 3'd5}: code = 8'h3B;
            {2'd2, 3'd0}: code = 8'h19;
            {2'd2, 3'd1}: code = 8'h1C;
            {2'd2, 3'd2}: code = 8'h29;
            {2'd2, 3'd3}: code = 8'h2C;
            {2'd2, 3'd4}: code = 8'h39;
            {2'd2, 3'd5}: code = 8'h3C;
            {2'd3, 3'd0}: code = 8'h1E;
            {2'd3, 3'd1}: code = 8'h1D;
            {2'd3, 3'd2}: code = 8'h2E;
            {2'd3, 3'd3}: code = 8'h2D;
            {2'd3, 3'd4}: code = 8'h3E;
            {2'd3, 3'd5}: code = 8'h3D;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

    // Segment pin levels for one COM, showing three BCD digits and the degree-C symbol.
    function automatic logic [NUM_SEG_PINS-1:0] segment_pattern(
        input logic [1:0]  com,
        input logic [11:0] bcd
    );
        logic [NUM_SEG_PINS-1:0] pins;
        logic [7:0]  code;
        logic [3:0]  dig;
        logic [3:0]  seg;
        logic [3:0]  sym;
        logic [15:0] lit;
        pins = '0;
        for (int p = 0; p < NUM_SEG_PINS; p++) begin
            code = com_seg_code(com, 3'(p));
            dig  = code[7:4];
            seg  = code[3:0];
            unique case (dig)
                4'd1:    sym = bcd[11:8];
                4'd2:    sym = bcd[7:4];
                4'd3:    sym = bcd[3:0];
                4'd4:    sym = SYM_DEG_C;
                default: sym = SYM_BLANK;
            endcase
            lit = seg_lit(sym);
            pins[p] = lit[seg];
        end
        return pins;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/seglcd_if.sv -----
// Handshake channel interfaces for ticks, results and configuration writes.
`default_nettype none

interface seglcd_tick_if;
    logic valid;
    logic ready;
    logic tick;
    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface seglcd_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] com_level;
    logic [5:0] seg_level;
    logic [3:0] com_float_mask;
    modport source (output valid, output com_level, output seg_level, output com_float_mask,
                    input ready);
    modport sink (input valid, input com_level, input seg_level, input com_float_mask,
                  output ready);
endinterface

interface seglcd_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/seglcd_cfg_regs.sv -----
// Configuration registers for the refresh and count periods.
`default_nettype none

module seglcd_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  logic               wr_index,
    input  logic [15:0]        wr_data,
    output seglcd_pkg::cfg_t   cfg
);
    import seglcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                REG_REFRESH_PERIOD: cfg_next.refresh_period = wr_data[7:0];
                REG_COUNT_PERIOD:   cfg_next.count_period = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refresh_period <= REFRESH_PERIOD_RST;
            cfg_reg.count_period   <= COUNT_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/seglcd_in_stage.sv -----
// Input register that holds one accepted tick item until the engine takes it.
`default_nettype none

module seglcd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_tick,
    input  logic                advance,
    output seglcd_pkg::stage_t  stage
);
    import seglcd_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;
    logic   accept;

    assign in_ready = !stage_reg.valid || advance;
    assign accept   = in_valid && in_ready;
    assign stage    = stage_reg;

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid = 1'b1;
            stage_next.tick  = in_tick;
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    // A held item must not vanish before the engine takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && !advance) |=> stage_reg.valid)
        else $error("input item dropped while engine stalled");

endmodule

`default_nettype wire

// ----- hdl/seglcd_engine.sv -----
// Drive state update per tick; the state registers double as the result register.
`default_nettype none

module seglcd_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  seglcd_pkg::cfg_t    cfg,
    input  seglcd_pkg::stage_t  stage,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          com_level,
    output logic [5:0]          seg_level,
    output logic [3:0]          com_float_mask
);
    import seglcd_pkg::*;

    logic [7:0]          refresh_ticks_reg, refresh_ticks_next;
    logic [15:0]         count_ticks_reg, count_ticks_next;
    logic [1:0]          active_com_reg, active_com_next;
    logic [11:0]         bcd_reg, bcd_next;
    logic [NUM_PINS-1:0] pin_levels_reg, pin_levels_next;
    logic [NUM_COM-1:0]  float_mask_reg, float_mask_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]  refresh_inc;
    logic [15:0] count_inc;
    logic [4:0]  ones_inc;
    logic [4:0]  tens_inc;
    logic [4:0]  hund_inc;
    logic [3:0]  ones_new;
    logic [3:0]  tens_new;
    logic [3:0]  hund_new;

    assign advance        = stage.valid && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign com_level      = pin_levels_reg[NUM_COM-1:0];
    assign seg_level      = pin_levels_reg[NUM_PINS-1:NUM_COM];
    assign com_float_mask = float_mask_reg;

    // BCD increment, modulo 1000.
    always_comb
    begin
        ones_inc = {1'b0, bcd_reg[3:0]} + 5'd1;
        tens_inc = {1'b0, bcd_reg[7:4]};
        hund_inc = {1'b0, bcd_reg[11:8]};
        if (ones_inc > 5'd9)
        begin
            ones_inc = 5'd0;
            tens_inc = tens_inc + 5'd1;
        end
        if (tens_inc > 5'd9)
        begin
            tens_inc = 5'd0;
            hund_inc = hund_inc + 5'd1;
        end
        if (hund_inc > 5'd9)
        begin
            hund_inc = 5'd0;
        end
        ones_new = ones_inc[3:0];
        tens_new = tens_inc[3:0];
        hund_new = hund_inc[3:0];
    end

    always_comb
    begin
        refresh_ticks_next = refresh_ticks_reg;
        count_ticks_next   = count_ticks_reg;
        active_com_next    = active_com_reg;
        bcd_next           = bcd_reg;
        pin_levels_next    = pin_levels_reg;
        float_mask_next    = float_mask_reg;
        out_valid_next     = out_valid_reg;
        refresh_inc        = refresh_ticks_reg + 8'd1;
        count_inc          = count_ticks_reg + 16'd1;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (stage.tick)
            begin
                refresh_ticks_next = refresh_inc;
                count_ticks_next   = count_inc;
                pin_levels_next    = ~pin_levels_reg;
                // A refresh shows the count from before any increment on the same tick.
                if (refresh_inc >= cfg.refresh_period)
                begin
                    refresh_ticks_next = '0;
                    active_com_next    = active_com_reg + 2'd1;
                    pin_levels_next    = {segment_pattern(active_com_reg + 2'd1, bcd_reg),
                                          {NUM_COM{1'b0}}};
                    float_mask_next    = ~(NUM_COM'(1) << (active_com_reg + 2'd1));
                end
                if (count_inc >= cfg.count_period)
                begin
                    count_ticks_next = '0;
                    bcd_next         = {hund_new, tens_new, ones_new};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_ticks_reg <= '0;
            count_ticks_reg   <= '0;
            active_com_reg    <= '0;
            bcd_reg           <= '0;
            pin_levels_reg    <= PIN_LEVELS_RST;
            float_mask_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            refresh_ticks_reg <= refresh_ticks_next;
            count_ticks_reg   <= count_ticks_next;
            active_com_reg    <= active_com_next;
            bcd_reg           <= bcd_next;
            pin_levels_reg    <= pin_levels_next;
            float_mask_reg    <= float_mask_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Either every COM is driven (after reset) or exactly one is.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(float_mask_reg) == 0) || ($countones(float_mask_reg) == NUM_COM - 1))
        else $error("float mask leaves more than one COM driven");

    // Each digit of the count stays a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bcd_reg[3:0] <= 4'd9) && (bcd_reg[7:4] <= 4'd9) && (bcd_reg[11:8] <= 4'd9))
        else $error("count left BCD range");

    // Drive levels change only when a new item is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(pin_levels_reg) && $stable(float_mask_reg)))
        else $error("pin levels changed without an item");

    // The driven COM follows the active COM after a refresh.
    assert property (@(posedge clk) disable iff (!rst_n)
        (float_mask_reg != '0) |-> !float_mask_reg[active_com_reg])
        else $error("active COM is floating");

endmodule

`default_nettype wire

// ----- hdl/segment_lcd_mux_driver.sv -----
// Top level of the multiplexed four-COM segment LCD driver.
// An accepted tick item is held in the input register and then loaded into the result register,
// from which its result item can be taken.
// Throughput: one tick item per cycle while result ready is high, set by the state update in the engine.
// While result ready is low the input register takes one more item, then input ready drops.
// Reset (rst_n low, asynchronous) restores default periods, count 000, COM1, all pins high.
`default_nettype none

module segment_lcd_mux_driver (
    input  logic              clk,
    input  logic              rst_n,
    seglcd_tick_if.sink       ticks,
    seglcd_result_if.source   results,
    seglcd_cfg_if.sink        cfg
);
    import seglcd_pkg::*;

    cfg_t   cfg_q;
    stage_t stage;
    logic   advance;

    seglcd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    seglcd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ticks.valid),
        .in_ready (ticks.ready),
        .in_tick  (ticks.tick),
        .advance  (advance),
        .stage    (stage)
    );

    seglcd_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_q),
        .stage          (stage),
        .advance        (advance),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .com_level      (results.com_level),
        .seg_level      (results.seg_level),
        .com_float_mask (results.com_float_mask)
    );

endmodule

`default_nettype wire
